### sv/qrv_pkg.sv
// Shared types and constants of the quaternion point rotator.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package qrv_pkg;

    localparam int COORD_W       = 24;
    localparam int QUAT_W        = 16;
    localparam int QUAT_FRAC_DEF = 14;
    // Rotation matrix entry: sum of four 16x16 products on the diagonal, else of two, doubled
    localparam int COEF_W        = 2 * QUAT_W + 2;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [QUAT_W-1:0]  t_quat;
    typedef logic signed [COEF_W-1:0]  t_coef;
    typedef t_coef [2:0]               t_coef_row;
    typedef t_coef_row [2:0]           t_coef_mat;
    typedef t_quat [3:0]               t_quat_vec;
    typedef t_coord [2:0]              t_point;

    localparam t_coord COORD_MAX  = {1'b0, {(COORD_W-1){1'b1}}};
    localparam t_coord COORD_MIN  = {1'b1, {(COORD_W-1){1'b0}}};
    localparam t_quat  QUAT_W_RST = 16'sd16384;

    // Configuration register index, also the slot in t_quat_vec
    typedef enum logic [1:0] {
        CFG_W = 2'd0,
        CFG_X = 2'd1,
        CFG_Y = 2'd2,
        CFG_Z = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        t_coord in_x;
        t_coord in_y;
        t_coord in_z;
        t_coord in_w;
    } t_in_item;

    typedef struct packed {
        t_coord out_x;
        t_coord out_y;
        t_coord out_z;
        t_coord out_w;
        logic   clamped;
    } t_out_item;

    // Load strobes for the three arithmetic stages of a row lane
    typedef struct packed {
        logic ld_mul;
        logic ld_sum;
        logic ld_out;
    } t_row_ctl;

endpackage

`default_nettype wire

### sv/qrv_coef.sv
// Rotation matrix builder: quaternion products, then the nine matrix entries.
// Two register stages; depends on qrv_pkg.
`default_nettype none

module qrv_coef (
    input  wire logic              i_clk,
    input  wire qrv_pkg::t_quat_vec i_quat,
    output qrv_pkg::t_coef_mat     o_mat
);
    import qrv_pkg::*;

    typedef logic signed [2*QUAT_W-1:0] t_prod;

    t_prod r_ww, r_xx, r_yy, r_zz;
    t_prod r_xy, r_xz, r_yz, r_wx, r_wy, r_wz;
    t_coef_mat r_mat;
    t_coef_mat n_mat;

    // Stage 1: all pairwise products
    always_ff @(posedge i_clk) begin
        r_ww <= $signed(i_quat[CFG_W]) * $signed(i_quat[CFG_W]);
        r_xx <= $signed(i_quat[CFG_X]) * $signed(i_quat[CFG_X]);
        r_yy <= $signed(i_quat[CFG_Y]) * $signed(i_quat[CFG_Y]);
        r_zz <= $signed(i_quat[CFG_Z]) * $signed(i_quat[CFG_Z]);
        r_xy <= $signed(i_quat[CFG_X]) * $signed(i_quat[CFG_Y]);
        r_xz <= $signed(i_quat[CFG_X]) * $signed(i_quat[CFG_Z]);
        r_yz <= $signed(i_quat[CFG_Y]) * $signed(i_quat[CFG_Z]);
        r_wx <= $signed(i_quat[CFG_W]) * $signed(i_quat[CFG_X]);
        r_wy <= $signed(i_quat[CFG_W]) * $signed(i_quat[CFG_Y]);
        r_wz <= $signed(i_quat[CFG_W]) * $signed(i_quat[CFG_Z]);
    end

    // Stage 2: matrix entries, row r gives output coordinate r
    always_comb begin
        n_mat[0][0] = COEF_W'(r_ww) + COEF_W'(r_xx) - COEF_W'(r_yy) - COEF_W'(r_zz);
        n_mat[0][1] = (COEF_W'(r_xy) - COEF_W'(r_wz)) <<< 1;
        n_mat[0][2] = (COEF_W'(r_xz) + COEF_W'(r_wy)) <<< 1;
        n_mat[1][0] = (COEF_W'(r_xy) + COEF_W'(r_wz)) <<< 1;
        n_mat[1][1] = COEF_W'(r_ww) - COEF_W'(r_xx) + COEF_W'(r_yy) - COEF_W'(r_zz);
        n_mat[1][2] = (COEF_W'(r_yz) - COEF_W'(r_wx)) <<< 1;
        n_mat[2][0] = (COEF_W'(r_xz) - COEF_W'(r_wy)) <<< 1;
        n_mat[2][1] = (COEF_W'(r_yz) + COEF_W'(r_wx)) <<< 1;
        n_mat[2][2] = COEF_W'(r_ww) - COEF_W'(r_xx) - COEF_W'(r_yy) + COEF_W'(r_zz);
    end

    always_ff @(posedge i_clk) begin
        r_mat <= n_mat;
    end

    assign o_mat = r_mat;

endmodule

`default_nettype wire

### sv/qrv_row.sv
// One output lane: matrix row times point, rounded half up, saturated.
// Three register stages under load strobes from the top; depends on qrv_pkg.
`default_nettype none

module qrv_row #(
    parameter int QUAT_FRAC_BITS = qrv_pkg::QUAT_FRAC_DEF
) (
    input  wire logic                i_clk,
    input  wire qrv_pkg::t_coef_row  i_coef,
    input  wire qrv_pkg::t_point     i_pt,
    input  wire qrv_pkg::t_row_ctl   i_ctl,
    output qrv_pkg::t_coord          o_val,
    output logic                     o_sat
);
    import qrv_pkg::*;

    localparam int SHIFT  = 2 * QUAT_FRAC_BITS;
    localparam int PROD_W = COEF_W + COORD_W;
    localparam int ACC_W  = ((PROD_W > SHIFT) ? PROD_W : SHIFT) + 3;
    localparam logic signed [ACC_W-1:0] ROUND_HALF =
        {{(ACC_W-SHIFT){1'b0}}, 1'b1, {(SHIFT-1){1'b0}}};

    logic signed [PROD_W-1:0] r_prod [3];
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  n_acc;
    logic signed [ACC_W-1:0]  n_shift;
    logic [ACC_W-COORD_W:0]   n_top;
    t_coord                   r_val, n_val;
    logic                     r_sat, n_sat;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_mul) begin
            for (int k = 0; k < 3; k++) begin
                r_prod[k] <= PROD_W'($signed(i_coef[k]) * $signed(i_pt[k]));
            end
        end
    end

    // Dot product plus half an LSB of the output scale
    assign n_acc = ACC_W'(r_prod[0]) + ACC_W'(r_prod[1]) + ACC_W'(r_prod[2])
                 + ROUND_HALF;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_sum) begin
            r_acc <= n_acc;
        end
    end

    // Floor to point scale, clamp when the upper bits are not pure sign
    always_comb begin
        n_shift = r_acc >>> SHIFT;
        n_top   = n_shift[ACC_W-1:COORD_W-1];
        if ((&n_top) || !(|n_top)) begin
            n_val = n_shift[COORD_W-1:0];
            n_sat = 1'b0;
        end else begin
            n_val = n_shift[ACC_W-1] ? COORD_MIN : COORD_MAX;
            n_sat = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_out) begin
            r_val <= n_val;
            r_sat <= n_sat;
        end
    end

    assign o_val = r_val;
    assign o_sat = r_sat;

endmodule

`default_nettype wire

### sv/quaternion_rotate_vector_unit.sv
// Quaternion point rotator, top level.
//
// Rotates the point (in_x, in_y, in_z) by the quaternion held in four config
// registers (w, x, y, z, signed Q2.14) and passes in_w through. Requests enter
// on i_valid/o_stall and leave on o_valid/i_stall; a request moves at a clock
// edge where valid is high and stall is low. Config writes use i_cfg_valid /
// o_cfg_ready (always ready), index 0..3 selects w, x, y, z.
// Throughput: one request per cycle while the output is not stalled.
// Three lanes each run multiply, sum-and-round, and clamp stages; three
// alignment stages in front cover the two-stage matrix build from the config
// registers, so a request that meets no stall uses the config written up to
// its accepting edge.
// Reset (i_rst_n low, synchronous) empties the pipe, holds o_stall high and
// restores the identity quaternion (w = 1.0).
// Stall: each stage advances when its successor is empty or advancing, so
// bubbles collapse while the output waits; o_stall rises only when all six
// stages hold requests and the output is stalled, or while in reset.
`default_nettype none

module quaternion_rotate_vector_unit #(
    parameter int QUAT_FRAC_BITS = qrv_pkg::QUAT_FRAC_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire qrv_pkg::t_in_item   i_data,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output qrv_pkg::t_out_item       o_data,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire qrv_pkg::t_cfg_idx   i_cfg_index,
    input  wire qrv_pkg::t_quat      i_cfg_data
);
    import qrv_pkg::*;

    localparam int NSTG = 6;

    t_quat_vec        r_quat;
    t_coef_mat        coef_mat;

    logic [NSTG-1:0]  r_vld;
    logic [NSTG-1:0]  stg_rdy;
    logic [NSTG-1:0]  stg_ld;
    logic [NSTG-1:0]  stg_src;

    t_in_item         r_s1, r_s2, r_s3;
    t_coord           r_w4, r_w5, r_w6;
    t_point           pt;
    t_row_ctl         row_ctl;
    t_coord           lane_val [3];
    logic [2:0]       lane_sat;

    // Config registers: always ready, ignore nothing but undefined codes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quat[CFG_W] <= QUAT_W_RST;
            r_quat[CFG_X] <= '0;
            r_quat[CFG_Y] <= '0;
            r_quat[CFG_Z] <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_W:   r_quat[CFG_W] <= i_cfg_data;
                CFG_X:   r_quat[CFG_X] <= i_cfg_data;
                CFG_Y:   r_quat[CFG_Y] <= i_cfg_data;
                CFG_Z:   r_quat[CFG_Z] <= i_cfg_data;
                default: r_quat <= r_quat;
            endcase
        end
    end

    qrv_coef u_coef (
        .i_clk  (i_clk),
        .i_quat (r_quat),
        .o_mat  (coef_mat)
    );

    // Ready chain from the output back: a stage loads when empty or draining
    always_comb begin
        stg_rdy[NSTG-1] = !r_vld[NSTG-1] || !i_stall;
        for (int k = NSTG - 2; k >= 0; k--) begin
            stg_rdy[k] = !r_vld[k] || stg_rdy[k+1];
        end
        stg_src = {r_vld[NSTG-2:0], i_valid};
        stg_ld  = stg_rdy & stg_src;
    end

    // Hold off upstream during reset so no request lands in a clearing stage
    assign o_stall = !stg_rdy[0] || !i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (stg_rdy[k]) begin
                    r_vld[k] <= stg_src[k];
                end
            end
        end
    end

    // Alignment stages carry the whole request; later stages carry only w
    always_ff @(posedge i_clk) begin
        if (stg_ld[0]) begin
            r_s1 <= i_data;
        end
        if (stg_ld[1]) begin
            r_s2 <= r_s1;
        end
        if (stg_ld[2]) begin
            r_s3 <= r_s2;
        end
        if (stg_ld[3]) begin
            r_w4 <= r_s3.in_w;
        end
        if (stg_ld[4]) begin
            r_w5 <= r_w4;
        end
        if (stg_ld[5]) begin
            r_w6 <= r_w5;
        end
    end

    assign pt[0] = r_s3.in_x;
    assign pt[1] = r_s3.in_y;
    assign pt[2] = r_s3.in_z;

    assign row_ctl.ld_mul = stg_ld[3];
    assign row_ctl.ld_sum = stg_ld[4];
    assign row_ctl.ld_out = stg_ld[5];

    for (genvar g = 0; g < 3; g++) begin : g_lane
        qrv_row #(
            .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
        ) u_row (
            .i_clk  (i_clk),
            .i_coef (coef_mat[g]),
            .i_pt   (pt),
            .i_ctl  (row_ctl),
            .o_val  (lane_val[g]),
            .o_sat  (lane_sat[g])
        );
    end

    // Output register is the last stage of the lanes plus w
    assign o_valid        = r_vld[NSTG-1];
    assign o_data.out_x   = lane_val[0];
    assign o_data.out_y   = lane_val[1];
    assign o_data.out_z   = lane_val[2];
    assign o_data.out_w   = r_w6;
    assign o_data.clamped = |lane_sat;

`ifndef SYNTHESIS
    // Upstream stalls only when every stage is occupied and the output waits
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && o_stall) |-> ((&r_vld) && i_stall))
        else $error("o_stall raised with room in the pipe");

    // A request that meets no stall on its way reaches the output
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && !i_stall) ##1 !i_stall ##1 !i_stall
        ##1 !i_stall ##1 !i_stall ##1 !i_stall |=> o_valid)
        else $error("request did not reach the output in time");

    // A clamp flag comes with at least one coordinate at a rail
    a_clamp_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.clamped) |->
        (o_data.out_x == COORD_MAX || o_data.out_x == COORD_MIN ||
         o_data.out_y == COORD_MAX || o_data.out_y == COORD_MIN ||
         o_data.out_z == COORD_MAX || o_data.out_z == COORD_MIN))
        else $error("clamped set without a saturated coordinate");
`endif

endmodule

`default_nettype wire

### verif/tb_top.sv
// Self-checking testbench for the quaternion point rotator.
// Depends on qrv_pkg and quaternion_rotate_vector_unit; holds a scoreboard class and the top.
`default_nettype none

module tb_top;
    import qrv_pkg::*;

    // Cycle budget: several times the slowest legal run.
    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int          RAND_PHASES = 12;
    localparam int          PHASE_ITEMS = 145;
    localparam int          SHIFT       = 2 * QUAT_FRAC_DEF;
    localparam int          MAX_REPORTS = 40;

    // Scoreboard: mirrors the quaternion registers, predicts each rotated point
    // when its request is accepted and checks results in arrival order.
    class rotated_point_board;
        t_quat       quat[4];
        t_out_item   pending[$];
        int          errors;
        int          checked;
        int          clamps;

        function new();
            quat[CFG_W] = QUAT_W_RST;
            quat[CFG_X] = '0;
            quat[CFG_Y] = '0;
            quat[CFG_Z] = '0;
            errors      = 0;
            checked     = 0;
            clamps      = 0;
        endfunction

        function void set_register(t_cfg_idx idx, t_quat val);
            quat[idx] = val;
        endfunction

        function bit idle();
            return pending.size() == 0;
        endfunction

        // Exact 64-bit sum of products, then round half up from 2^SHIFT and clamp.
        function t_out_item rotate_point(t_in_item req);
            longint signed qw, qx, qy, qz;
            longint signed sw, sx, sy, sz;
            longint signed m[3][3];
            longint signed p[3];
            longint signed acc;
            t_coord        rot[3];
            t_out_item     r;
            logic          sat;
            qw = quat[CFG_W];
            qx = quat[CFG_X];
            qy = quat[CFG_Y];
            qz = quat[CFG_Z];
            sw = qw * qw;
            sx = qx * qx;
            sy = qy * qy;
            sz = qz * qz;
            m[0][0] = sw + sx - sy - sz;
            m[0][1] = 2 * (qx * qy - qw * qz);
            m[0][2] = 2 * (qx * qz + qw * qy);
            m[1][0] = 2 * (qx * qy + qw * qz);
            m[1][1] = sw - sx + sy - sz;
            m[1][2] = 2 * (qy * qz - qw * qx);
            m[2][0] = 2 * (qx * qz - qw * qy);
            m[2][1] = 2 * (qy * qz + qw * qx);
            m[2][2] = sw - sx - sy + sz;
            p[0] = $signed(req.in_x);
            p[1] = $signed(req.in_y);
            p[2] = $signed(req.in_z);
            sat  = 1'b0;
            for (int row = 0; row < 3; row++) begin
                acc = m[row][0] * p[0] + m[row][1] * p[1] + m[row][2] * p[2];
                acc = (acc + (longint'(1) <<< (SHIFT - 1))) >>> SHIFT;
                if (acc > longint'(COORD_MAX)) begin
                    acc = COORD_MAX;
                    sat = 1'b1;
                end else if (acc < longint'(COORD_MIN)) begin
                    acc = COORD_MIN;
                    sat = 1'b1;
                end
                rot[row] = acc[COORD_W-1:0];
            end
            r.out_x   = rot[0];
            r.out_y   = rot[1];
            r.out_z   = rot[2];
            r.out_w   = req.in_w;
            r.clamped = sat;
            return r;
        endfunction

        function void note_request(t_in_item req);
            pending.push_back(rotate_point(req));
        endfunction

        function void match(string what, longint e, longint a);
            if (e != a) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t mismatch %s: expected %0d actual %0d", $time, what, e, a);
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t unexpected result: expected none actual %h", $time, got);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (want.clamped)
                clamps++;
            match("out_x", want.out_x, got.out_x);
            match("out_y", want.out_y, got.out_y);
            match("out_z", want.out_z, got.out_z);
            match("out_w", want.out_w, got.out_w);
            match("clamped", want.clamped, got.clamped);
        endfunction
    endclass

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic       o_stall;
    t_in_item   i_data      = '0;
    logic       o_valid;
    logic       i_stall     = 1'b0;
    t_out_item  o_data;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    t_cfg_idx   i_cfg_index = CFG_W;
    t_quat      i_cfg_data  = '0;

    // Suppress all idling in some phases so the pipe runs back to back.
    logic        quiet      = 1'b0;
    int          stall_left = 0;
    int unsigned cycles     = 0;
    int          sent       = 0;
    int          settings   = 1;

    rotated_point_board board = new();

    quaternion_rotate_vector_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Hold the run to a hard cycle budget.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycles, board.pending.size());
            $display("FAIL quaternion_rotate_vector_unit");
            $finish;
        end
    end

    // Receiver back-pressure: runs of stall or no stall, mostly short, a few long.
    always @(posedge i_clk) begin
        if (!i_rst_n || quiet) begin
            i_stall    <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else begin
            i_stall    <= ($urandom_range(0, 99) < 35);
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                      : $urandom_range(0, 3);
        end
    end

    // Check every result the moment it is taken.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            board.check_result(o_data);
    end

    function automatic int send_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_coord pick_coord(int kind);
        case (kind)
            0:       return t_coord'($urandom());
            1:       return t_coord'($urandom_range(0, 8191) - 4096);
            default: begin
                case ($urandom_range(0, 5))
                    0:       return COORD_MAX;
                    1:       return COORD_MIN;
                    2:       return '0;
                    3:       return t_coord'(1);
                    4:       return '1;
                    default: return t_coord'($urandom());
                endcase
            end
        endcase
    endfunction

    // Mostly full-range points, some small ones, some built from corner values.
    function automatic t_in_item random_point();
        t_in_item pt;
        int       r;
        int       kind;
        r    = $urandom_range(0, 99);
        kind = (r < 55) ? 0 : (r < 80) ? 1 : 2;
        pt.in_x = pick_coord(kind);
        pt.in_y = pick_coord(kind);
        pt.in_z = pick_coord(kind);
        pt.in_w = t_coord'($urandom());
        return pt;
    endfunction

    // Hold the request until the block takes it; note it at the accepting edge.
    task automatic send_request(t_in_item req);
        int gap;
        gap = send_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= req;
        do @(posedge i_clk); while (o_stall);
        board.note_request(req);
        sent++;
    endtask

    // Always wait for a clock edge first so valid never toggles within a step.
    task automatic wait_drained();
        do @(posedge i_clk); while (!board.idle());
    endtask

    task automatic write_register(t_cfg_idx idx, t_quat val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_register(idx, val);
    endtask

    // Drop the request line, drain the pipe, then load all four registers.
    task automatic load_quaternion(t_quat qw, t_quat qx, t_quat qy, t_quat qz);
        i_valid <= 1'b0;
        wait_drained();
        write_register(CFG_W, qw);
        write_register(CFG_X, qx);
        write_register(CFG_Y, qy);
        write_register(CFG_Z, qz);
        i_cfg_valid <= 1'b0;
        settings++;
    endtask

    initial begin
        t_in_item corner_pts[8];
        t_quat    qs[4];

        corner_pts[0] = '{'0, '0, '0, '0};
        corner_pts[1] = '{COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX};
        corner_pts[2] = '{COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN};
        corner_pts[3] = '{COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN};
        corner_pts[4] = '{COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX};
        corner_pts[5] = '{t_coord'(1), '1, t_coord'(1), '1};
        corner_pts[6] = '{'1, '1, '1, '0};
        corner_pts[7] = '{24'h555555, 24'hAAAAAA, 24'h00FFFF, 24'hFF0000};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: corner points under the reset identity, the all-negative
        // full-scale quaternion, and the largest non-unit quaternion.
        foreach (corner_pts[k]) send_request(corner_pts[k]);
        load_quaternion(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        foreach (corner_pts[k]) send_request(corner_pts[k]);
        load_quaternion(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        foreach (corner_pts[k]) send_request(corner_pts[k]);

        // Random phases, each under its own quaternion.
        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            case (phase)
                0: qs = '{QUAT_W_RST, 16'sd0, 16'sd0, 16'sd0};
                1: qs = '{16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF};
                2: qs = '{16'sd0, 16'sd0, 16'sd0, 16'sd0};
                3: qs = '{16'sd0, 16'sd16384, 16'sd0, 16'sd0};
                4: qs = '{16'sd11585, 16'sd0, 16'sd0, 16'sd11585};
                default: begin
                    foreach (qs[i]) begin
                        if (phase % 2 == 0)
                            qs[i] = t_quat'($urandom());
                        else
                            qs[i] = t_quat'($urandom_range(0, 24000) - 12000);
                    end
                end
            endcase
            load_quaternion(qs[0], qs[1], qs[2], qs[3]);
            quiet <= (phase % 4 == 1);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Pause the sender once mid-phase until the pipe is empty.
                if (phase == 6 && n == 70) begin
                    i_valid <= 1'b0;
                    wait_drained();
                end
                send_request(random_point());
            end
        end

        i_valid <= 1'b0;
        quiet   <= 1'b0;
        wait_drained();
        repeat (20) @(posedge i_clk);

        $display("sent %0d points under %0d quaternion settings", sent, settings);
        $display("checked %0d results, %0d of them clamped, %0d errors",
                 board.checked, board.clamps, board.errors);
        if (board.errors == 0 && board.idle())
            $display("PASS quaternion_rotate_vector_unit");
        else
            $display("FAIL quaternion_rotate_vector_unit");
        $finish;
    end

endmodule

`default_nettype wire
